FILE: sv/hdtm_pkg.sv
// ----------------------------------------------------------------------------
// hdtm_pkg - shared constants for the hard disk trial move core
// Coordinate width, register map codes and register reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hdtm_pkg;

  // coordinate format: unsigned Q8.8 box units
  localparam int unsigned COORD_BITS    = 16;
  localparam int unsigned MAX_DISKS_DEF = 256;

  // configuration register map (word index into paddr)
  localparam int unsigned  REG_IDX_W      = 2;
  localparam logic [1:0]   REG_DISK_COUNT = 2'd0;
  localparam logic [1:0]   REG_RADIUS     = 2'd1;
  localparam logic [1:0]   REG_BOX_SIZE   = 2'd2;

  // register widths and reset values
  localparam int unsigned  COUNT_W   = 9;
  localparam int unsigned  RADIUS_W  = 15;
  localparam logic [8:0]   COUNT_RST  = 9'd1;
  localparam logic [14:0]  RADIUS_RST = 15'd256;
  localparam logic [15:0]  BOX_RST    = 16'd65535;

  // item function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_MOVE = 1'b1;

endpackage

`default_nettype wire

FILE: sv/hard_disk_trial_move_core.sv
// ----------------------------------------------------------------------------
// hard_disk_trial_move_core - Metropolis trial move for equal-radius disks
// Stores disk positions, applies load and trial move transactions, and checks
// a moved disk for overlap against every other active disk.
// ----------------------------------------------------------------------------
// A load, or a transaction whose index is not below the active count, goes to
// S_OUT. A trial move reads the old position in S_OLD, then visits the active
// disks in turn: the moved disk, or one at least a diameter away on x or y, is
// passed in S_DIFF alone, others go through S_DIFF, S_SQX, S_SQY and S_CMP;
// the scan stops early on the first overlap found. It is paced by the single
// read port of the position RAM, which visits one stored disk at a time, and
// by the one shared 16x16 squarer that forms dx^2 and dy^2 in turn. in_ready_o
// is high only between transactions; a finished result sits in the output
// register, so the next transaction is taken while it waits to be collected.
`timescale 1ns / 1ps
`default_nettype none

module hard_disk_trial_move_core
  import hdtm_pkg::*;
#(
  parameter int unsigned MAX_DISKS = MAX_DISKS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // input channel
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  func_i,
  input  wire logic [7:0]            disk_index_i,
  input  wire logic [COORD_BITS-1:0] load_x_i,
  input  wire logic [COORD_BITS-1:0] load_y_i,
  input  wire logic signed [15:0]    step_x_i,
  input  wire logic signed [15:0]    step_y_i,
  // result channel
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       accepted_o,
  output logic                       index_error_o,
  output logic [COORD_BITS-1:0]      final_x_o,
  output logic [COORD_BITS-1:0]      final_y_o,
  // configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [3:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int unsigned AW    = (MAX_DISKS > 1) ? $clog2(MAX_DISKS) : 1;
  localparam int unsigned CW    = $clog2(MAX_DISKS + 1);
  localparam int unsigned ACT_W = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned SQ_W  = 2 * CB;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OLD  = 3'd1;
  localparam logic [2:0] S_DIFF = 3'd2;
  localparam logic [2:0] S_SQX  = 3'd3;
  localparam logic [2:0] S_SQY  = 3'd4;
  localparam logic [2:0] S_CMP  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  // clamp old + step to [r, box - r]; lower bound first, then upper, then 0
  function automatic logic [CB-1:0] clamp_coord(input logic [CB-1:0]       old,
                                                input logic signed [15:0]  step,
                                                input logic [RADIUS_W-1:0] r,
                                                input logic [CB-1:0]       box);
    logic signed [CB+1:0] v;
    logic signed [CB+1:0] lo;
    logic signed [CB+1:0] hi;
    v  = signed'({2'b00, old}) + signed'((CB+2)'(step));
    lo = signed'((CB+2)'(r));
    hi = signed'({2'b00, box}) - lo;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    if (v < 0)  v = '0;
    return v[CB-1:0];
  endfunction

  function automatic logic [CB-1:0] abs_diff(input logic [CB-1:0] a,
                                             input logic [CB-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [COUNT_W-1:0]   disk_count_q;
  logic [RADIUS_W-1:0]  disk_radius_q;
  logic [CB-1:0]        box_size_q;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_count_q  <= COUNT_RST;
      disk_radius_q <= RADIUS_RST;
      box_size_q    <= BOX_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DISK_COUNT: disk_count_q  <= pwdata[COUNT_W-1:0];
        REG_RADIUS:     disk_radius_q <= pwdata[RADIUS_W-1:0];
        REG_BOX_SIZE:   box_size_q    <= pwdata[CB-1:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (cfg_idx)
      REG_DISK_COUNT: prdata = 32'(disk_count_q);
      REG_RADIUS:     prdata = 32'(disk_radius_q);
      REG_BOX_SIZE:   prdata = 32'(box_size_q);
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  logic [2:0]            state_q, state_d;
  logic [ACT_W-1:0]      j_q, j_d;
  logic [ACT_W-1:0]      active_q, active_d;
  logic [ACT_W-1:0]      idx_q, idx_d;
  logic signed [15:0]    step_x_q, step_x_d, step_y_q, step_y_d;
  logic [CB-1:0]         ox_q, ox_d, oy_q, oy_d;
  logic [CB-1:0]         nx_q, nx_d, ny_q, ny_d;
  logic [CB-1:0]         dx_q, dx_d, dy_q, dy_d;
  logic [SQ_W-1:0]       lim2_q, lim2_d;
  logic [SQ_W-1:0]       sqx_q, sqx_d, sqy_q, sqy_d;
  logic                  res_acc_q, res_acc_d, res_err_q, res_err_d;
  logic [CB-1:0]         res_x_q, res_x_d, res_y_q, res_y_d;
  logic                  out_valid_q;

  // position RAM, x in the low half
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [2*CB-1:0]       ram_wdata, ram_rdata;

  hdtm_ram #(
    .WIDTH (2 * CB),
    .DEPTH (MAX_DISKS)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared squarer
  logic [CB-1:0]   sq_a;
  logic [SQ_W-1:0] sq_p;
  logic [CB-1:0]   lim;

  assign lim  = {disk_radius_q, 1'b0};
  assign sq_p = SQ_W'(sq_a) * SQ_W'(sq_a);

  always_comb begin
    unique case (state_q)
      S_SQX:   sq_a = dx_q;
      S_SQY:   sq_a = dy_q;
      default: sq_a = lim;
    endcase
  end

  // per-item decode on acceptance
  logic [ACT_W-1:0] idx_ext, cnt_ext, max_ext, active_c;
  logic             in_fire, out_fire;

  assign idx_ext  = ACT_W'(disk_index_i);
  assign cnt_ext  = ACT_W'(disk_count_q);
  assign max_ext  = ACT_W'(MAX_DISKS);
  assign active_c = (cnt_ext < max_ext) ? cnt_ext : max_ext;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  // loop helpers
  logic [ACT_W-1:0] j_next;
  logic [CB-1:0]    px, py, dx_c, dy_c;
  logic             skip_c, last_c, overlap_c;
  logic [SQ_W:0]    dist2;

  assign j_next    = j_q + 1'b1;
  assign last_c    = (j_next == active_q);
  assign px        = ram_rdata[CB-1:0];
  assign py        = ram_rdata[2*CB-1:CB];
  assign dx_c      = abs_diff(nx_q, px);
  assign dy_c      = abs_diff(ny_q, py);
  assign skip_c    = (j_q == idx_q) || (dx_c >= lim) || (dy_c >= lim);
  assign dist2     = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign overlap_c = (dist2 < {1'b0, lim2_q});

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    j_d       = j_q;
    active_d  = active_q;
    idx_d     = idx_q;
    step_x_d  = step_x_q;
    step_y_d  = step_y_q;
    ox_d      = ox_q;
    oy_d      = oy_q;
    nx_d      = nx_q;
    ny_d      = ny_q;
    dx_d      = dx_q;
    dy_d      = dy_q;
    lim2_d    = lim2_q;
    sqx_d     = sqx_q;
    sqy_d     = sqy_q;
    res_acc_d = res_acc_q;
    res_err_d = res_err_q;
    res_x_d   = res_x_q;
    res_y_d   = res_y_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q[AW-1:0];
    ram_wdata = {ny_q, nx_q};
    ram_re    = 1'b0;
    ram_raddr = j_next[AW-1:0];

    unique case (state_q)
      // take a transaction; loads and bad indices finish at once
      S_IDLE: begin
        if (in_fire) begin
          idx_d    = idx_ext;
          active_d = active_c;
          step_x_d = step_x_i;
          step_y_d = step_y_i;
          if (idx_ext >= active_c) begin
            res_acc_d = 1'b0;
            res_err_d = 1'b1;
            res_x_d   = '0;
            res_y_d   = '0;
            state_d   = S_OUT;
          end else if (func_i == FUNC_LOAD) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(disk_index_i);
            ram_wdata = {load_y_i, load_x_i};
            res_acc_d = 1'b1;
            res_err_d = 1'b0;
            res_x_d   = load_x_i;
            res_y_d   = load_y_i;
            state_d   = S_OUT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = AW'(disk_index_i);
            state_d   = S_OLD;
          end
        end
      end
      // old position in hand: clamp, square the diameter, start the scan
      S_OLD: begin
        ox_d      = ram_rdata[CB-1:0];
        oy_d      = ram_rdata[2*CB-1:CB];
        nx_d      = clamp_coord(ram_rdata[CB-1:0], step_x_q, disk_radius_q, box_size_q);
        ny_d      = clamp_coord(ram_rdata[2*CB-1:CB], step_y_q, disk_radius_q,
                                box_size_q);
        lim2_d    = sq_p;
        j_d       = '0;
        ram_re    = 1'b1;
        ram_raddr = '0;
        state_d   = S_DIFF;
      end
      // distances to disk j; far disks and self are passed without squaring
      S_DIFF: begin
        dx_d = dx_c;
        dy_d = dy_c;
        if (!skip_c) begin
          state_d = S_SQX;
        end else if (last_c) begin
          ram_we    = 1'b1;
          res_acc_d = 1'b1;
          res_err_d = 1'b0;
          res_x_d   = nx_q;
          res_y_d   = ny_q;
          state_d   = S_OUT;
        end else begin
          j_d     = j_next;
          ram_re  = 1'b1;
          state_d = S_DIFF;
        end
      end
      S_SQX: begin
        sqx_d   = sq_p;
        state_d = S_SQY;
      end
      S_SQY: begin
        sqy_d   = sq_p;
        state_d = S_CMP;
      end
      // overlap test against the squared diameter
      S_CMP: begin
        if (overlap_c) begin
          res_acc_d = 1'b0;
          res_err_d = 1'b0;
          res_x_d   = ox_q;
          res_y_d   = oy_q;
          state_d   = S_OUT;
        end else if (last_c) begin
          ram_we    = 1'b1;
          res_acc_d = 1'b1;
          res_err_d = 1'b0;
          res_x_d   = nx_q;
          res_y_d   = ny_q;
          state_d   = S_OUT;
        end else begin
          j_d     = j_next;
          ram_re  = 1'b1;
          state_d = S_DIFF;
        end
      end
      // hand the result to the output register once it is free
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == S_OUT) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    j_q       <= j_d;
    active_q  <= active_d;
    idx_q     <= idx_d;
    step_x_q  <= step_x_d;
    step_y_q  <= step_y_d;
    ox_q      <= ox_d;
    oy_q      <= oy_d;
    nx_q      <= nx_d;
    ny_q      <= ny_d;
    dx_q      <= dx_d;
    dy_q      <= dy_d;
    lim2_q    <= lim2_d;
    sqx_q     <= sqx_d;
    sqy_q     <= sqy_d;
    res_acc_q <= res_acc_d;
    res_err_q <= res_err_d;
    res_x_q   <= res_x_d;
    res_y_q   <= res_y_d;
    if ((state_q == S_OUT) && (!out_valid_q || out_ready_i)) begin
      accepted_o    <= res_acc_q;
      index_error_o <= res_err_q;
      final_x_o     <= res_x_q;
      final_y_o     <= res_y_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // a position write always ends the transaction
  a_write_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> (state_q == S_OUT))
    else $error("position write not followed by result stage");

  // an index error never reports an accepted transaction
  a_err_not_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(accepted_o && index_error_o))
    else $error("result both accepted and in error");

  // the scan never runs past the active disks
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DIFF) || (state_q == S_SQX) || (state_q == S_SQY) ||
     (state_q == S_CMP)) |-> (j_q < active_q))
    else $error("scan index beyond active count");

  // the moved disk is inside the active range when the move starts
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OLD) |-> (idx_q < active_q))
    else $error("move started on an inactive disk");

  // an accepted transaction always leaves idle
  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != S_IDLE))
    else $error("transaction accepted without leaving idle");
`endif

endmodule

`default_nettype wire

FILE: sv/hdtm_ram.sv
// ----------------------------------------------------------------------------
// hdtm_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hdtm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: tb/hdtm_tb_pkg.sv
// ----------------------------------------------------------------------------
// hdtm_tb_pkg - transaction types and scoreboard for the disk move testbench
// Holds a mirror of the disk positions and the configuration, works out the
// outcome of every accepted request and checks the core's results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hdtm_tb_pkg;

  import hdtm_pkg::*;

  typedef struct packed {
    logic               func;
    logic [7:0]         index;
    logic [15:0]        load_x;
    logic [15:0]        load_y;
    logic signed [15:0] step_x;
    logic signed [15:0] step_y;
  } disk_request_t;

  typedef struct packed {
    logic        accepted;
    logic        index_error;
    logic [15:0] final_x;
    logic [15:0] final_y;
  } disk_outcome_t;

  class disk_move_scoreboard;

    // mirrored state and configuration
    logic [15:0]   pos_x [MAX_DISKS_DEF];
    logic [15:0]   pos_y [MAX_DISKS_DEF];
    logic [8:0]    disk_count;
    logic [14:0]   disk_radius;
    logic [15:0]   box_size;
    disk_outcome_t expected_outcomes [$];
    int unsigned   fail_count;
    int unsigned   checked_count;

    function new();
      foreach (pos_x[i]) begin
        pos_x[i] = '0;
        pos_y[i] = '0;
      end
      disk_count    = COUNT_RST;
      disk_radius   = RADIUS_RST;
      box_size      = BOX_RST;
      fail_count    = 0;
      checked_count = 0;
    endfunction

    function void set_register(logic [1:0] code, logic [31:0] value);
      case (code)
        REG_DISK_COUNT: disk_count  = value[8:0];
        REG_RADIUS:     disk_radius = value[14:0];
        REG_BOX_SIZE:   box_size    = value[15:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_outcomes.size();
    endfunction

    function void report(string msg);
      fail_count++;
      if (fail_count <= 100) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    // lower bound first, then upper bound; a negative upper bound gives 0
    function logic [15:0] clamp_axis(logic [15:0] old, logic signed [15:0] step);
      int lo;
      int hi;
      int v;
      lo = disk_radius;
      hi = box_size;
      hi = hi - lo;
      v  = old;
      v  = v + step;
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[15:0];
    endfunction

    // strict overlap test against every other active disk
    function bit collides(int unsigned idx, logic [15:0] x, logic [15:0] y,
                          int unsigned active);
      longint lim;
      longint lim_sq;
      longint dx;
      longint dy;
      lim    = 2 * longint'(disk_radius);
      lim_sq = lim * lim;
      for (int unsigned j = 0; j < active; j++) begin
        if (j == idx) continue;
        dx = (x > pos_x[j]) ? longint'(x - pos_x[j]) : longint'(pos_x[j] - x);
        dy = (y > pos_y[j]) ? longint'(y - pos_y[j]) : longint'(pos_y[j] - y);
        if (dx >= lim || dy >= lim) continue;
        if (dx * dx + dy * dy < lim_sq) return 1'b1;
      end
      return 1'b0;
    endfunction

    // work out the outcome of an accepted request and queue it
    function void note_request(disk_request_t req);
      disk_outcome_t o;
      int unsigned   active;
      int unsigned   idx;
      logic [15:0]   nx;
      logic [15:0]   ny;
      o      = '0;
      active = (disk_count < MAX_DISKS_DEF) ? disk_count : MAX_DISKS_DEF;
      idx    = req.index;
      if (idx >= active) begin
        o.index_error = 1'b1;
      end else if (req.func == FUNC_LOAD) begin
        pos_x[idx] = req.load_x;
        pos_y[idx] = req.load_y;
        o.accepted = 1'b1;
        o.final_x  = req.load_x;
        o.final_y  = req.load_y;
      end else begin
        nx = clamp_axis(pos_x[idx], req.step_x);
        ny = clamp_axis(pos_y[idx], req.step_y);
        if (collides(idx, nx, ny, active)) begin
          o.final_x = pos_x[idx];
          o.final_y = pos_y[idx];
        end else begin
          pos_x[idx] = nx;
          pos_y[idx] = ny;
          o.accepted = 1'b1;
          o.final_x  = nx;
          o.final_y  = ny;
        end
      end
      // append to the tail of the expected queue
      expected_outcomes = {expected_outcomes, o};
    endfunction

    // compare a result transaction with the oldest expected outcome
    function void check_outcome(disk_outcome_t got);
      disk_outcome_t want;
      if (expected_outcomes.size() == 0) begin
        report($sformatf("unexpected result acc=%0b err=%0b x=%0d y=%0d",
                         got.accepted, got.index_error, got.final_x, got.final_y));
        return;
      end
      want = expected_outcomes.pop_front();
      checked_count++;
      if (got.accepted !== want.accepted)
        report($sformatf("result %0d accepted %0b, want %0b",
                         checked_count, got.accepted, want.accepted));
      if (got.index_error !== want.index_error)
        report($sformatf("result %0d index_error %0b, want %0b",
                         checked_count, got.index_error, want.index_error));
      if (got.final_x !== want.final_x)
        report($sformatf("result %0d final_x %0d, want %0d",
                         checked_count, got.final_x, want.final_x));
      if (got.final_y !== want.final_y)
        report($sformatf("result %0d final_y %0d, want %0d",
                         checked_count, got.final_y, want.final_y));
    endfunction

  endclass

endpackage

FILE: tb/tb_hard_disk_trial_move_core.sv
// ----------------------------------------------------------------------------
// tb_hard_disk_trial_move_core - testbench for the hard disk trial move core
// Directed loads, index errors, touching and overlapping disks and clamp
// corner cases, then randomised configuration phases of load and move
// transactions with random idling on both channels, checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_hard_disk_trial_move_core;

  import hdtm_pkg::*;
  import hdtm_tb_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1450;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  logic               func_i       = FUNC_LOAD;
  logic [7:0]         disk_index_i = '0;
  logic [15:0]        load_x_i     = '0;
  logic [15:0]        load_y_i     = '0;
  logic signed [15:0] step_x_i     = '0;
  logic signed [15:0] step_y_i     = '0;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  logic               accepted_o;
  logic               index_error_o;
  logic [15:0]        final_x_o;
  logic [15:0]        final_y_o;
  logic               psel         = 1'b0;
  logic               penable      = 1'b0;
  logic               pwrite       = 1'b0;
  logic [3:0]         paddr        = '0;
  logic [31:0]        pwdata       = '0;
  logic [31:0]        prdata;
  logic               pready;

  disk_move_scoreboard sb = new();

  // stimulus bookkeeping
  bit          calm;             // no idling on either side while set
  bit          loaded [256];
  int unsigned active_disks = 1;
  int unsigned cur_radius   = RADIUS_RST;
  int unsigned cur_box      = BOX_RST;
  int unsigned items_sent;

  hard_disk_trial_move_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .disk_index_i  (disk_index_i),
    .load_x_i      (load_x_i),
    .load_y_i      (load_y_i),
    .step_x_i      (step_x_i),
    .step_y_i      (step_y_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .accepted_o    (accepted_o),
    .index_error_o (index_error_o),
    .final_x_o     (final_x_o),
    .final_y_o     (final_y_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk_i = ~clk_i;

  // result side: check each transaction, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_outcome('{accepted_o, index_error_o, final_x_o, final_y_o});
    out_ready_i <= calm || ($urandom_range(99) >= 19);
  end

  function automatic int unsigned idle_gap();
    int unsigned n;
    n = 0;
    if (!calm)
      while ($urandom_range(99) < 19) n++;
    return n;
  endfunction

  // present one request and wait until it is taken
  task automatic send_item(disk_request_t req);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= req.func;
    disk_index_i <= req.index;
    load_x_i     <= req.load_x;
    load_y_i     <= req.load_y;
    step_x_i     <= req.step_x;
    step_y_i     <= req.step_y;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(req);
    if (req.func == FUNC_LOAD && req.index < active_disks) loaded[req.index] = 1'b1;
    items_sent++;
  endtask

  task automatic send_load(int unsigned idx, logic [15:0] x, logic [15:0] y);
    disk_request_t req;
    req = '{FUNC_LOAD, idx[7:0], x, y, 16'($urandom), 16'($urandom)};
    send_item(req);
  endtask

  task automatic send_move(int unsigned idx, logic signed [15:0] sx,
                           logic signed [15:0] sy);
    disk_request_t req;
    req = '{FUNC_MOVE, idx[7:0], 16'($urandom), 16'($urandom), sx, sy};
    send_item(req);
  endtask

  // let every outstanding result come back with the input channel quiet
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(logic [1:0] code, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {code, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_register(code, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_config(int unsigned count, int unsigned radius,
                              int unsigned box);
    drain();
    write_register(REG_DISK_COUNT, count);
    write_register(REG_RADIUS, radius);
    write_register(REG_BOX_SIZE, box);
    active_disks = (count < 256) ? count : 256;
    cur_radius   = radius;
    cur_box      = box;
  endtask

  // mostly short hops around a diameter, sometimes any displacement
  function automatic logic [15:0] pick_step();
    int span;
    if ($urandom_range(3) == 0) return 16'($urandom);
    span = 2 * cur_radius + 2;
    if (span > 32767) span = 32767;
    return 16'(int'($urandom_range(2 * span)) - span);
  endfunction

  function automatic logic [15:0] pick_coord();
    if ($urandom_range(4) == 0) return 16'($urandom);
    return 16'($urandom_range(cur_box));
  endfunction

  task automatic random_item();
    int unsigned   r;
    disk_request_t req;
    r = $urandom_range(99);
    if (active_disks == 0 || (r >= 85 && active_disks < 256)) begin
      // out-of-range index, everything else noise
      req = '{1'($urandom), 8'($urandom_range(255, active_disks)), 16'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom)};
      send_item(req);
    end else if (r < 70 || r >= 85) begin
      send_move($urandom_range(active_disks - 1), pick_step(), pick_step());
    end else begin
      send_load($urandom_range(active_disks - 1), pick_coord(), pick_coord());
    end
  endtask

  // main stimulus
  initial begin
    int unsigned phase;
    int unsigned n;
    int unsigned count;
    int unsigned radius;
    int unsigned box;

    calm = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration: a single disk, index errors, extreme loads and steps
    send_load(1, 16'd10, 16'd20);
    send_move(255, 16'sd5, 16'sd5);
    send_load(0, 16'hFFFF, 16'hFFFF);
    send_move(0, 16'sd0, 16'sd0);
    send_load(0, 16'h0000, 16'h0000);
    send_move(0, 16'sh7FFF, 16'sh7FFF);
    send_move(0, -16'sh8000, -16'sh8000);

    // no active disks: every index is out of range
    apply_config(0, 256, 65535);
    send_load(0, 16'd100, 16'd100);
    send_move(0, 16'sd1, 16'sd1);

    // two disks: touching is allowed, one step closer overlaps
    apply_config(2, 100, 1000);
    send_load(0, 16'd500, 16'd500);
    send_load(1, 16'd700, 16'd500);
    send_move(1, 16'sd0, 16'sd0);
    send_move(1, -16'sd1, 16'sd0);
    send_move(1, -16'sd60, 16'sd160);
    send_move(0, 16'sd2000, 16'sd2000);

    // clamp corners: upper bound below lower, negative upper bound, huge radius
    apply_config(1, 600, 1000);
    send_move(0, 16'sd0, 16'sd0);
    apply_config(1, 2000, 1000);
    send_move(0, 16'sd5, 16'sd5);
    apply_config(1, 32767, 0);
    send_move(0, 16'sh7FFF, -16'sh8000);
    apply_config(1, 32767, 65535);
    send_move(0, -16'sh8000, 16'sh7FFF);

    // random phases, each with its own configuration
    items_sent = 0;
    phase      = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (phase == 0) begin
        count  = 256;
        box    = 65535;
        radius = $urandom_range(2000, 1200);
      end else if (phase == 1) begin
        count  = $urandom_range(4, 2);
        box    = 65535;
        radius = 32767;
      end else if (phase % 5 == 4) begin
        count  = $urandom_range(24, 2);
        box    = $urandom_range(65535);
        radius = 1;
      end else begin
        count  = ($urandom_range(7) == 0) ? 1 : $urandom_range(24, 2);
        box    = ($urandom_range(5) == 0) ? $urandom_range(400) :
                                            $urandom_range(65535, 400);
        radius = box / $urandom_range(16, 4) + 1;
      end
      apply_config(count, radius, box);
      calm = (phase == 2);
      for (int unsigned i = 0; i < active_disks; i++)
        if (!loaded[i]) send_load(i, pick_coord(), pick_coord());
      n = $urandom_range(140, 60);
      repeat (n) random_item();
      phase++;
    end
    calm = 1'b0;

    drain();
    repeat (50) @(posedge clk_i);
    if (sb.fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // watchdog
  initial begin
    #(100_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
